// ----- hdl/mls_pkg.sv -----
// mls_pkg: shared types, status codes and constants for the label switch
// no dependencies
`timescale 1ns / 1ps
package mls_pkg;
   localparam logic [3:0] ST_MPLS   = 4'd0;
   localparam logic [3:0] ST_IPV4   = 4'd1;
   localparam logic [3:0] ST_IPV6   = 4'd2;
   localparam logic [3:0] ST_TTL    = 4'd3;
   localparam logic [3:0] ST_NOENT  = 4'd4;
   localparam logic [3:0] ST_EMPTY  = 4'd5;
   localparam logic [3:0] ST_LOOP   = 4'd6;
   localparam logic [3:0] ST_BADIF  = 4'd7;
   localparam logic [3:0] ST_OVFL   = 4'd8;

   localparam logic [1:0] OP_INVALID = 2'd0;
   localparam logic [1:0] OP_SWAP    = 2'd1;
   localparam logic [1:0] OP_PUSH    = 2'd2;
   localparam logic [1:0] OP_POP     = 2'd3;

   localparam logic [4:0] IF_NONE   = 5'h1f;
   localparam logic [19:0] LBL_NULL4 = 20'd0;
   localparam logic [19:0] LBL_NULL6 = 20'd2;

   // table entry
   typedef struct packed {
      logic [4:0]  in_if;
      logic [19:0] in_label;
      logic [1:0]  op;
      logic [19:0] out_label;
      logic [4:0]  out_if;
   } entry_type;

   // controller to datapath commands
   typedef struct packed {
      logic load;       // capture packet from input
      logic scan_start; // reset search pointer
      logic scan_step;  // advance search pointer
      logic pop_null;   // pop explicit null on top
      logic apply;      // apply found entry
      logic set_none;   // lookup interface becomes internal
      logic finish;     // capture result
      logic [3:0] fin_status;
      logic fin_stack;  // show stack in result
      logic fin_ttl;    // show ttl in result
      logic [4:0] fin_if;
   } cmd_type;

   // datapath to controller status
   typedef struct packed {
      logic ttl_low;
      logic empty;
      logic top_null;
      logic top_null6;
      logic bottom;
      logic full;
      logic scan_hit;
      logic scan_end;
      entry_type hit;
      logic if_ok;
   } stat_type;
endpackage

// ----- hdl/mpls_label_switch.sv -----
// mpls_label_switch: top level, stream ports, csr register, result holding
// depends on mls_pkg, mls_control, mls_datapath
`timescale 1ns / 1ps
// Table writes give no response. A packet is loaded and then checked, each
// popped explicit null takes a pass step of its own, and each label pass
// runs a first-match search of the table that walks one entry per cycle
// through its single read port (at most LOOP_LIMIT passes), then a forward
// step captures a forwarded stack, then the response is shown and held
// until taken; the next request is taken once the response has been handed
// over. The table resets to all entries invalid at once through per-entry
// valid bits.
module mpls_label_switch #(
   parameter int TABLE_ENTRIES = 64,
   parameter int MAX_DEPTH = 4,
   parameter int LOOP_LIMIT = 8
) (
   input  logic clock,
   input  logic reset,
   input  logic csr_we,
   input  logic [15:0] csr_wdata,
   input  logic req_tvalid,
   output logic req_tready,
   // tuser: action
   input  logic req_tuser,
   // tdata low up: in_if, ttl_in, depth_in, label_0..label_3, entry_slot,
   // entry_op, entry_out_if, zero fill
   input  logic [111:0] req_tdata,
   output logic rsp_tvalid,
   input  logic rsp_tready,
   // tdata low up: status, out_if, ttl_out, depth_out, out_label_0..3, zero fill
   output logic [103:0] rsp_tdata
);
   logic [15:0] mask_ff;
   always_ff @(posedge clock) begin
      if (reset) mask_ff <= '0;
      else if (csr_we) mask_ff <= csr_wdata;
   end

   logic busy, done, start, wr_en;
   mls_pkg::cmd_type cmd;
   mls_pkg::stat_type stat;
   mls_pkg::entry_type we;
   logic [3:0] r_status;
   logic [4:0] r_if;
   logic [7:0] r_ttl;
   logic [2:0] r_depth;
   logic [79:0] r_labels;

   assign req_tready = !busy;
   assign start = req_tvalid && req_tready && !req_tuser;
   assign wr_en = req_tvalid && req_tready && req_tuser;
   assign we.in_if = req_tdata[4:0];
   assign we.in_label = req_tdata[35:16];
   assign we.out_label = req_tdata[55:36];
   assign we.op = req_tdata[103:102];
   assign we.out_if = req_tdata[108:104];

   mls_control #(.LOOP_LIMIT(LOOP_LIMIT)) u_ctl (
      .clock, .reset, .start, .stat, .rsp_free(rsp_tready), .cmd, .busy, .done);

   mls_datapath #(.TABLE_ENTRIES(TABLE_ENTRIES), .MAX_DEPTH(MAX_DEPTH)) u_dp (
      .clock, .reset, .mask(mask_ff), .wr_en, .wr_slot(req_tdata[101:96]),
      .wr_entry(we), .pk_if(req_tdata[4:0]), .pk_ttl(req_tdata[12:5]),
      .pk_depth(req_tdata[15:13]), .pk_labels(req_tdata[95:16]), .cmd, .stat,
      .r_status, .r_if, .r_ttl, .r_depth, .r_labels);

   assign rsp_tvalid = done;
   assign rsp_tdata = {4'd0, r_labels, r_depth, r_ttl, r_if, r_status};
endmodule

// ----- hdl/mls_datapath.sv -----
// mls_datapath: label table memory, label stack, table search pointer and result register
// depends on mls_pkg
`timescale 1ns / 1ps
module mls_datapath #(
   parameter int TABLE_ENTRIES = 64,
   parameter int MAX_DEPTH = 4
) (
   input  logic clock,
   input  logic reset,
   input  logic [15:0] mask,
   input  logic wr_en,
   input  logic [5:0] wr_slot,
   input  mls_pkg::entry_type wr_entry,
   input  logic [4:0] pk_if,
   input  logic [7:0] pk_ttl,
   input  logic [2:0] pk_depth,
   input  logic [79:0] pk_labels,
   input  mls_pkg::cmd_type cmd,
   output mls_pkg::stat_type stat,
   output logic [3:0] r_status,
   output logic [4:0] r_if,
   output logic [7:0] r_ttl,
   output logic [2:0] r_depth,
   output logic [79:0] r_labels
);
   localparam int AW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
   localparam int SW = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH + 1) : 1;
   localparam int DW = 4; // stack storage rows (shown labels)
   localparam int SD = (MAX_DEPTH > DW) ? MAX_DEPTH : DW;

   mls_pkg::entry_type mem [TABLE_ENTRIES];
   logic [TABLE_ENTRIES-1:0] valid_ff;
   mls_pkg::entry_type rd_ff;
   logic [AW:0] ptr_ff, rdptr_ff;
   logic rdv_ff;
   logic [19:0] stk_ff [SD];
   logic [SW-1:0] n_ff;
   logic [4:0] ifc_ff;
   logic [7:0] ttl_ff;
   logic ttl_low_ff;
   logic [AW-1:0] wr_idx;
   logic wr_ok;

   assign wr_idx = AW'(wr_slot);
   assign wr_ok = wr_en && (32'(wr_slot) < TABLE_ENTRIES);

   // table writes, valid bits and registered search read
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (wr_ok) begin
         valid_ff[wr_idx] <= (wr_entry.op != mls_pkg::OP_INVALID);
      end
      if (wr_ok)
         mem[wr_idx] <= wr_entry;
      // read data holds on a hit so the found entry stays visible
      if (cmd.scan_step) begin
         rd_ff <= mem[ptr_ff[AW-1:0]];
         rdv_ff <= (ptr_ff < (AW+1)'(TABLE_ENTRIES)) && valid_ff[ptr_ff[AW-1:0]];
         rdptr_ff <= ptr_ff;
      end
   end

   // search pointer
   always_ff @(posedge clock) begin
      if (cmd.scan_start) ptr_ff <= '0;
      else if (cmd.scan_step && ptr_ff < (AW+1)'(TABLE_ENTRIES)) ptr_ff <= ptr_ff + 1'b1;
   end

   // label stack
   logic [2:0] dclip;
   always_comb begin
      dclip = (pk_depth > 3'd4) ? 3'd4 : pk_depth;
      if (32'(dclip) > MAX_DEPTH) dclip = 3'(MAX_DEPTH);
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         for (int k = 0; k < SD; k++)
            stk_ff[k] <= (k < 4) ? pk_labels[20*(k%4) +: 20] : 20'd0;
         n_ff <= SW'(dclip);
         ifc_ff <= pk_if;
         ttl_ff <= pk_ttl - 8'd1;
         ttl_low_ff <= (pk_ttl <= 8'd1);
      end else if (cmd.pop_null || (cmd.apply && rd_ff.op == mls_pkg::OP_POP)) begin
         for (int k = 0; k < SD - 1; k++) stk_ff[k] <= stk_ff[k+1];
         n_ff <= n_ff - 1'b1;
      end else if (cmd.apply && rd_ff.op == mls_pkg::OP_PUSH) begin
         for (int k = 1; k < SD; k++) stk_ff[k] <= stk_ff[k-1];
         stk_ff[0] <= rd_ff.out_label;
         n_ff <= n_ff + 1'b1;
      end else if (cmd.apply) begin
         stk_ff[0] <= rd_ff.out_label;
      end
      if (cmd.set_none) ifc_ff <= mls_pkg::IF_NONE;
   end

   // status toward controller
   always_comb begin
      stat.ttl_low = ttl_low_ff;
      stat.empty = (n_ff == '0);
      stat.top_null = (stk_ff[0] == mls_pkg::LBL_NULL4) || (stk_ff[0] == mls_pkg::LBL_NULL6);
      stat.top_null6 = (stk_ff[0] == mls_pkg::LBL_NULL6);
      stat.bottom = (n_ff == SW'(1));
      stat.full = (32'(n_ff) >= MAX_DEPTH);
      stat.scan_hit = rdv_ff && rd_ff.in_if == ifc_ff && rd_ff.in_label == stk_ff[0];
      stat.scan_end = (rdptr_ff >= (AW+1)'(TABLE_ENTRIES));
      stat.hit = rd_ff;
      stat.if_ok = mask[rd_ff.out_if[3:0]];
   end

   // result register, depth saturates at 7
   always_ff @(posedge clock) begin
      if (cmd.finish) begin
         r_status <= cmd.fin_status;
         r_if <= cmd.fin_if;
         r_ttl <= cmd.fin_ttl ? ttl_ff : 8'd0;
         r_depth <= !cmd.fin_stack ? 3'd0 : (32'(n_ff) > 7) ? 3'd7 : 3'(n_ff);
         for (int k = 0; k < 4; k++)
            r_labels[20*k +: 20] <= (cmd.fin_stack && k < 32'(n_ff)) ? stk_ff[k] : 20'd0;
      end
   end
endmodule

// ----- hdl/mls_control.sv -----
// mls_control: sequencer for ttl check, label passes and first-match table search
// depends on mls_pkg
`timescale 1ns / 1ps
module mls_control #(
   parameter int LOOP_LIMIT = 8
) (
   input  logic clock,
   input  logic reset,
   input  logic start,
   input  mls_pkg::stat_type stat,
   input  logic rsp_free,
   output mls_pkg::cmd_type cmd,
   output logic busy,
   output logic done
);
   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_CHK  = 3'd1;
   localparam logic [2:0] S_PASS = 3'd2;
   localparam logic [2:0] S_SCAN = 3'd3;
   localparam logic [2:0] S_WAIT = 3'd4;
   localparam logic [2:0] S_OUT  = 3'd5;
   localparam logic [2:0] S_FWD  = 3'd6;
   localparam int PW = $clog2(LOOP_LIMIT + 1);

   logic [2:0] state_ff, state_in;
   logic [PW-1:0] pass_ff, pass_in;
   logic [1:0] lat_ff, lat_in;

   always_comb begin
      state_in = state_ff;
      pass_in = pass_ff;
      lat_in = lat_ff;
      cmd = '0;
      cmd.fin_if = mls_pkg::IF_NONE;
      done = 1'b0;
      case (state_ff)
         S_IDLE: begin
            if (start) begin cmd.load = 1'b1; state_in = S_CHK; end
         end
         S_CHK: begin
            pass_in = '0;
            if (stat.ttl_low) begin
               cmd.finish = 1'b1; cmd.fin_status = mls_pkg::ST_TTL; state_in = S_OUT;
            end else if (stat.empty) begin
               cmd.finish = 1'b1; cmd.fin_status = mls_pkg::ST_EMPTY; state_in = S_OUT;
            end else state_in = S_PASS;
         end
         S_PASS: begin
            if (32'(pass_ff) >= LOOP_LIMIT) begin
               cmd.finish = 1'b1; cmd.fin_status = mls_pkg::ST_LOOP; state_in = S_OUT;
            end else if (stat.top_null) begin
               pass_in = pass_ff + 1'b1;
               if (stat.bottom) begin
                  cmd.finish = 1'b1; cmd.fin_ttl = 1'b1;
                  cmd.fin_status = stat.top_null6 ? mls_pkg::ST_IPV6 : mls_pkg::ST_IPV4;
                  state_in = S_OUT;
               end else cmd.pop_null = 1'b1;
            end else begin
               cmd.scan_start = 1'b1; lat_in = 2'd0; state_in = S_SCAN;
            end
         end
         S_SCAN: begin
            // the registered table read must fill before the first compare in S_WAIT
            cmd.scan_step = 1'b1;
            lat_in = lat_ff + 1'b1;
            if (lat_ff == 2'd0) state_in = S_WAIT;
         end
         S_WAIT: begin
            cmd.scan_step = 1'b1;
            if (stat.scan_end) begin
               cmd.finish = 1'b1; cmd.fin_status = mls_pkg::ST_NOENT; state_in = S_OUT;
            end else if (stat.scan_hit) begin
               cmd.scan_step = 1'b0;
               pass_in = pass_ff + 1'b1;
               if (stat.hit.op == mls_pkg::OP_PUSH && stat.full) begin
                  cmd.finish = 1'b1; cmd.fin_status = mls_pkg::ST_OVFL; state_in = S_OUT;
               end else if (stat.hit.op == mls_pkg::OP_POP && stat.bottom) begin
                  cmd.finish = 1'b1; cmd.fin_status = mls_pkg::ST_IPV4;
                  cmd.fin_ttl = 1'b1; cmd.fin_if = stat.hit.out_if; state_in = S_OUT;
               end else if (!stat.hit.out_if[4] && !stat.if_ok) begin
                  cmd.finish = 1'b1; cmd.fin_status = mls_pkg::ST_BADIF; state_in = S_OUT;
               end else if (!stat.hit.out_if[4]) begin
                  cmd.apply = 1'b1;
                  state_in = S_FWD;
               end else begin
                  cmd.apply = 1'b1; cmd.set_none = 1'b1; state_in = S_PASS;
               end
            end
         end
         S_FWD: begin
            // stack now updated; capture forward result with entry interface
            cmd.finish = 1'b1; cmd.fin_status = mls_pkg::ST_MPLS;
            cmd.fin_stack = 1'b1; cmd.fin_ttl = 1'b1; cmd.fin_if = stat.hit.out_if;
            state_in = S_OUT;
         end
         S_OUT: begin
            done = 1'b1;
            if (rsp_free) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         pass_ff <= '0;
         lat_ff <= '0;
      end else begin
         state_ff <= state_in;
         pass_ff <= pass_in;
         lat_ff <= lat_in;
      end
   end
   assign busy = (state_ff != S_IDLE);

   a_out_done: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_OUT) |-> done) else $error("result not presented");
   a_pass_lim: assert property (@(posedge clock) disable iff (reset)
      32'(pass_ff) <= LOOP_LIMIT) else $error("pass count overrun");
   a_load: assert property (@(posedge clock) disable iff (reset)
      cmd.load |=> (state_ff == S_CHK)) else $error("load not followed by check");
endmodule

// ----- tb/mpls_label_switch_tb.sv -----
// mpls_label_switch_tb: self-checking bench for the label switch
// depends on mls_pkg and mpls_label_switch
`timescale 1ns / 1ps
module mpls_label_switch_tb;

   localparam int N_SLOTS = 64;
   localparam int STACK_MAX = 4;
   localparam int PASS_MAX = 8;
   localparam int N_RANDOM = 1930;
   localparam int WATCHDOG = 20000;

   // first field in the lowest bits, as on rsp_tdata
   typedef struct packed {
      logic [19:0] lbl3;
      logic [19:0] lbl2;
      logic [19:0] lbl1;
      logic [19:0] lbl0;
      logic [2:0]  depth;
      logic [7:0]  ttl;
      logic [4:0]  out_if;
      logic [3:0]  status;
   } verdict_type;

   typedef struct packed {
      logic        wr;
      logic [4:0]  in_if;
      logic [7:0]  ttl;
      logic [2:0]  depth;
      logic [19:0] l0;
      logic [19:0] l1;
      logic [19:0] l2;
      logic [19:0] l3;
      logic [5:0]  slot;
      logic [1:0]  op;
      logic [4:0]  oif;
   } frame_type;

   // directed row: frame, whether the verdict is typed in, and that verdict
   typedef struct {
      frame_type   fr;
      logic        fixed;
      verdict_type v;
   } row_type;

   logic clock = 0;
   logic reset = 1;
   logic csr_we = 0;
   logic [15:0] csr_wdata = '0;
   logic req_tvalid = 0;
   logic req_tready;
   logic req_tuser = 0;
   logic [111:0] req_tdata = '0;
   logic rsp_tvalid;
   logic rsp_tready = 0;
   logic [103:0] rsp_tdata;

   mls_pkg::entry_type fib [N_SLOTS];
   logic [15:0] core_mask;
   verdict_type pending_verdicts[$];
   frame_type   stim_q[$];
   int          mismatches = 0;
   int          quiet_cycles = 0;
   bit          stim_done = 0;
   bit          hold_long = 0;
   bit          sending = 0;
   row_type     rows[$];

   mpls_label_switch dut (
      .clock(clock), .reset(reset), .csr_we(csr_we), .csr_wdata(csr_wdata),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tuser(req_tuser),
      .req_tdata(req_tdata), .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   function automatic verdict_type discard(logic [3:0] st);
      verdict_type v;
      v = '0;
      v.status = st;
      v.out_if = mls_pkg::IF_NONE;
      return v;
   endfunction

   // label stack walk for one packet; table writes update the local table
   function automatic logic forward_packet(frame_type f, output verdict_type v);
      logic [19:0] stk [STACK_MAX+1];
      int n, s, hit;
      logic [4:0] ifc;
      logic [7:0] ttl;
      mls_pkg::entry_type e;
      v = '0;
      if (f.wr) begin
         fib[f.slot] = '{f.in_if, f.l0, f.op, f.l1, f.oif};
         return 0;
      end
      if (f.ttl <= 1) begin
         v = discard(mls_pkg::ST_TTL);
         return 1;
      end
      ttl = f.ttl - 8'd1;
      n = (f.depth > STACK_MAX) ? STACK_MAX : f.depth;
      if (n == 0) begin
         v = discard(mls_pkg::ST_EMPTY);
         return 1;
      end
      stk[0] = f.l0; stk[1] = f.l1; stk[2] = f.l2; stk[3] = f.l3; stk[4] = '0;
      ifc = f.in_if;
      for (int pass = 0; pass < PASS_MAX; pass++) begin
         // explicit null pops without a lookup
         if (stk[0] == mls_pkg::LBL_NULL4 || stk[0] == mls_pkg::LBL_NULL6) begin
            if (n == 1) begin
               v = '0;
               v.status = (stk[0] == mls_pkg::LBL_NULL4) ? mls_pkg::ST_IPV4
                                                          : mls_pkg::ST_IPV6;
               v.out_if = mls_pkg::IF_NONE;
               v.ttl = ttl;
               return 1;
            end
            for (int k = 0; k < STACK_MAX - 1; k++) stk[k] = stk[k+1];
            n--;
            continue;
         end
         hit = -1;
         for (s = 0; s < N_SLOTS; s++)
            if (hit < 0 && fib[s].op != mls_pkg::OP_INVALID && fib[s].in_if == ifc &&
                fib[s].in_label == stk[0]) hit = s;
         if (hit < 0) begin
            v = discard(mls_pkg::ST_NOENT);
            return 1;
         end
         e = fib[hit];
         case (e.op)
            mls_pkg::OP_SWAP: stk[0] = e.out_label;
            mls_pkg::OP_PUSH: begin
               if (n >= STACK_MAX) begin
                  v = discard(mls_pkg::ST_OVFL);
                  return 1;
               end
               for (int k = STACK_MAX; k > 0; k--) stk[k] = stk[k-1];
               stk[0] = e.out_label;
               n++;
            end
            default: begin
               if (n == 1) begin
                  v = '0;
                  v.status = mls_pkg::ST_IPV4;
                  v.out_if = e.out_if;
                  v.ttl = ttl;
                  return 1;
               end
               for (int k = 0; k < STACK_MAX - 1; k++) stk[k] = stk[k+1];
               n--;
            end
         endcase
         if (!e.out_if[4]) begin
            if (!core_mask[e.out_if[3:0]]) begin
               v = discard(mls_pkg::ST_BADIF);
               return 1;
            end
            v.status = mls_pkg::ST_MPLS;
            v.out_if = e.out_if;
            v.ttl = ttl;
            v.depth = 3'(n);
            v.lbl0 = stk[0];
            v.lbl1 = (n > 1) ? stk[1] : '0;
            v.lbl2 = (n > 2) ? stk[2] : '0;
            v.lbl3 = (n > 3) ? stk[3] : '0;
            return 1;
         end
         ifc = mls_pkg::IF_NONE;
      end
      v = discard(mls_pkg::ST_LOOP);
      return 1;
   endfunction

   function automatic logic [111:0] pack_frame(frame_type f);
      return {3'd0, f.oif, f.op, f.slot, f.l3, f.l2, f.l1, f.l0, f.depth, f.ttl, f.in_if};
   endfunction

   function automatic frame_type entry_write(logic [4:0] mif, logic [19:0] ml,
         logic [1:0] op, logic [19:0] ol, logic [4:0] oif, logic [5:0] slot);
      frame_type f;
      f = '0;
      f.wr = 1; f.in_if = mif; f.l0 = ml; f.l1 = ol; f.op = op; f.oif = oif;
      f.slot = slot;
      return f;
   endfunction

   function automatic frame_type packet(logic [4:0] ifc, logic [7:0] ttl,
         logic [2:0] d, logic [19:0] a, logic [19:0] b, logic [19:0] c,
         logic [19:0] x);
      frame_type f;
      f = '0;
      f.in_if = ifc; f.ttl = ttl; f.depth = d;
      f.l0 = a; f.l1 = b; f.l2 = c; f.l3 = x;
      return f;
   endfunction

   // random frame; labels mostly from a small pool so lookups hit
   function automatic frame_type random_frame();
      frame_type f;
      logic [19:0] pool [8];
      pool = '{20'd0, 20'd2, 20'd16, 20'd17, 20'd18, 20'd19, 20'd3, 20'hfffff};
      f = '0;
      f.wr = ($urandom_range(0, 3) == 0);
      f.in_if = ($urandom_range(0, 2) == 0) ? mls_pkg::IF_NONE : 5'($urandom_range(0, 3));
      f.ttl = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(0, 1))
                                         : 8'($urandom_range(0, 255));
      f.depth = 3'($urandom_range(0, 7));
      f.l0 = ($urandom_range(0, 9) == 0) ? 20'($urandom) : pool[$urandom_range(0, 7)];
      f.l1 = ($urandom_range(0, 9) == 0) ? 20'($urandom) : pool[$urandom_range(0, 7)];
      f.l2 = ($urandom_range(0, 9) == 0) ? 20'($urandom) : pool[$urandom_range(0, 7)];
      f.l3 = ($urandom_range(0, 9) == 0) ? 20'($urandom) : pool[$urandom_range(0, 7)];
      f.slot = ($urandom_range(0, 4) == 0) ? 6'($urandom) : 6'($urandom_range(0, 7));
      f.op = 2'($urandom_range(0, 3));
      f.oif = ($urandom_range(0, 1) == 0) ? mls_pkg::IF_NONE : 5'($urandom_range(0, 15));
      return f;
   endfunction

   // wait until every packet has its response, then let the block settle
   task automatic drain();
      while (pending_verdicts.size() != 0 || stim_q.size() != 0 || sending || req_tvalid)
         @(posedge clock);
      repeat (10) @(posedge clock);
   endtask

   task automatic write_mask(logic [15:0] m);
      @(negedge clock);
      csr_we <= 1;
      csr_wdata <= m;
      @(negedge clock);
      csr_we <= 0;
      core_mask = m;
   endtask

   // sender: one transaction per queued frame, random gaps
   initial begin
      frame_type f;
      verdict_type v;
      int w;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         @(negedge clock);
         if (stim_q.size() == 0) begin
            req_tvalid <= 0;
         end else begin
            f = stim_q.pop_front();
            sending = 1;
            w = $urandom_range(0, 14);
            if (w > 0) begin
               req_tvalid <= 0;
               repeat (w) @(negedge clock);
            end
            req_tvalid <= 1;
            req_tuser <= f.wr;
            req_tdata <= pack_frame(f);
            @(posedge clock);
            while (!req_tready) @(posedge clock);
            if (forward_packet(f, v)) pending_verdicts.insert(pending_verdicts.size(), v);
            sending = 0;
         end
      end
   end

   // receiver: random wait per transaction, one long hold-off on request
   initial begin
      int w;
      rsp_tready <= 0;
      forever begin
         @(negedge clock);
         if (hold_long) begin
            rsp_tready <= 0;
            repeat (3000) @(negedge clock);
            hold_long = 0;
         end
         w = $urandom_range(0, 14);
         if (w > 0) begin
            rsp_tready <= 0;
            repeat (w) @(negedge clock);
         end
         rsp_tready <= 1;
         @(posedge clock);
         while (!rsp_tvalid) @(posedge clock);
      end
   end

   // response checker
   always @(posedge clock) begin
      verdict_type exp_v, got;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = rsp_tdata[99:0];
         if (pending_verdicts.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected response %h", got);
         end else begin
            exp_v = pending_verdicts.pop_front();
            if (got !== exp_v) begin
               mismatches++;
               if (mismatches <= 10)
                  $display({"mismatch: expected st=%0d if=%0d ttl=%0d d=%0d %h %h %h %h,",
                            " got st=%0d if=%0d ttl=%0d d=%0d %h %h %h %h"},
                     exp_v.status, exp_v.out_if, exp_v.ttl, exp_v.depth,
                     exp_v.lbl0, exp_v.lbl1, exp_v.lbl2, exp_v.lbl3,
                     got.status, got.out_if, got.ttl, got.depth,
                     got.lbl0, got.lbl1, got.lbl2, got.lbl3);
            end
         end
      end
   end

   // watchdog on cycles without a transaction
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || hold_long || reset)
         quiet_cycles <= 0;
      else if (!stim_done || pending_verdicts.size() != 0)
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG) begin
         $display("Some tests failed");
         $finish;
      end
   end

   initial begin
      verdict_type v;
      for (int s = 0; s < N_SLOTS; s++) fib[s] = '0;
      core_mask = '0;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 0;

      // after reset: every entry invalid, mask clear
      rows.insert(rows.size(), '{packet(5'd0, 8'd64, 3'd1, 20'd16, 20'd0, 20'd0, 20'd0),
         1'b1, discard(mls_pkg::ST_NOENT)});
      rows.insert(rows.size(), '{packet(5'd0, 8'd0, 3'd1, 20'd16, 20'd0, 20'd0, 20'd0),
         1'b1, discard(mls_pkg::ST_TTL)});
      rows.insert(rows.size(), '{packet(5'd3, 8'd1, 3'd4, 20'hfffff, 20'd0, 20'd0, 20'd0),
         1'b1, discard(mls_pkg::ST_TTL)});
      rows.insert(rows.size(), '{packet(5'd0, 8'd255, 3'd0, 20'd16, 20'd0, 20'd0, 20'd0),
         1'b1, discard(mls_pkg::ST_EMPTY)});
      v = '0; v.status = mls_pkg::ST_IPV4; v.out_if = mls_pkg::IF_NONE; v.ttl = 8'd254;
      rows.insert(rows.size(), '{packet(5'd0, 8'd255, 3'd1, 20'd0, 20'd0, 20'd0, 20'd0),
         1'b1, v});
      v.status = mls_pkg::ST_IPV6; v.ttl = 8'd1;
      rows.insert(rows.size(), '{packet(5'd15, 8'd2, 3'd7, 20'd0, 20'd0, 20'd0, 20'd2),
         1'b1, v});
      rows.insert(rows.size(), '{entry_write(5'd0, 20'd16, mls_pkg::OP_SWAP, 20'd17, 5'd5,
         6'd0), 1'b0, v});
      rows.insert(rows.size(), '{packet(5'd0, 8'd9, 3'd1, 20'd16, 20'd0, 20'd0, 20'd0),
         1'b1, discard(mls_pkg::ST_BADIF)});
      rows.insert(rows.size(), '{entry_write(5'd0, 20'd18, mls_pkg::OP_PUSH, 20'hfffff,
         5'd15, 6'd1), 1'b0, v});
      rows.insert(rows.size(), '{entry_write(5'd0, 20'd19, mls_pkg::OP_POP, 20'd0,
         mls_pkg::IF_NONE, 6'd63), 1'b0, v});
      rows.insert(rows.size(), '{entry_write(mls_pkg::IF_NONE, 20'd3, mls_pkg::OP_SWAP,
         20'd3, mls_pkg::IF_NONE, 6'd2), 1'b0, v});
      rows.insert(rows.size(), '{entry_write(5'd15, 20'd3, mls_pkg::OP_SWAP, 20'd3,
         mls_pkg::IF_NONE, 6'd3), 1'b0, v});
      rows.insert(rows.size(), '{entry_write(mls_pkg::IF_NONE, 20'hfffff, mls_pkg::OP_PUSH,
         20'd2, mls_pkg::IF_NONE, 6'd4), 1'b0, v});
      rows.insert(rows.size(), '{packet(5'd0, 8'd9, 3'd4, 20'd18, 20'd1, 20'd2, 20'd3),
         1'b1, discard(mls_pkg::ST_OVFL)});
      rows.insert(rows.size(), '{packet(5'd0, 8'd9, 3'd2, 20'd18, 20'd5, 20'd0, 20'd0),
         1'b0, v});
      rows.insert(rows.size(), '{packet(5'd0, 8'd9, 3'd1, 20'd19, 20'd0, 20'd0, 20'd0),
         1'b0, v});
      rows.insert(rows.size(), '{packet(5'd0, 8'd9, 3'd3, 20'd19, 20'd2, 20'd0, 20'd0),
         1'b0, v});
      rows.insert(rows.size(), '{packet(5'd15, 8'd9, 3'd1, 20'd3, 20'd0, 20'd0, 20'd0),
         1'b1, discard(mls_pkg::ST_LOOP)});
      rows.insert(rows.size(), '{packet(5'd0, 8'd9, 3'd2, 20'd19, 20'hfffff, 20'd0, 20'd0),
         1'b0, v});
      rows.insert(rows.size(), '{packet(5'd0, 8'd9, 3'd2, 20'd0, 20'd16, 20'd0, 20'd0),
         1'b0, v});
      rows.insert(rows.size(), '{entry_write(5'd0, 20'd18, mls_pkg::OP_INVALID, 20'd0,
         5'd0, 6'd1), 1'b0, v});
      rows.insert(rows.size(), '{packet(5'd0, 8'd9, 3'd1, 20'd18, 20'd0, 20'd0, 20'd0),
         1'b1, discard(mls_pkg::ST_NOENT)});

      // typed verdicts hold for the first run, with the mask clear
      for (int i = 0; i < rows.size(); i++) begin
         if (forward_packet(rows[i].fr, v) && rows[i].fixed && v !== rows[i].v) begin
            mismatches++;
            if (mismatches <= 10)
               $display("table row %0d predicts st=%0d, row says st=%0d",
                  i, v.status, rows[i].v.status);
         end
      end
      for (int s = 0; s < N_SLOTS; s++) fib[s] = '0;
      core_mask = '0;

      // directed rows run with the mask clear, then again fully set
      for (int i = 0; i < rows.size(); i++) stim_q.insert(stim_q.size(), rows[i].fr);
      drain();
      write_mask(16'hffff);
      for (int i = 0; i < rows.size(); i++) stim_q.insert(stim_q.size(), rows[i].fr);
      drain();

      // random phases across several mask settings, one long receiver hold
      for (int ph = 0; ph < 5; ph++) begin
         case (ph)
            0: write_mask(16'h0000);
            1: write_mask(16'h8001);
            2: write_mask(16'($urandom));
            3: write_mask(16'hffff);
            default: write_mask(16'h5a5a);
         endcase
         if (ph == 2) hold_long = 1;
         for (int i = 0; i < N_RANDOM / 5; i++) stim_q.insert(stim_q.size(), random_frame());
         drain();
      end
      stim_done = 1;
      repeat (200) @(posedge clock);
      if (mismatches == 0 && pending_verdicts.size() == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end
endmodule
